### sv/mtt_pkg.sv
// shared types and codes for the timer table
`timescale 1ns / 1ps
package mtt_pkg;
   typedef enum logic [2:0] {
      FN_CREATE = 3'd0, FN_START = 3'd1, FN_STOP = 3'd2, FN_DESTROY = 3'd3,
      FN_CHPER = 3'd4, FN_TICK = 3'd5, FN_REPORT = 3'd6, FN_BAD = 3'd7
   } func_type;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_INVAL = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] BE_NONE = 2'd0;
   localparam logic [1:0] BE_WARN = 2'd1;
   localparam logic [1:0] BE_FAULT = 2'd2;
   localparam logic [1:0] REG_TICK = 2'd0;
   localparam logic [1:0] REG_SOFT = 2'd1;
   localparam logic [1:0] REG_HARD = 2'd2;
   localparam logic [1:0] REG_STRIKE = 2'd3;
endpackage

### sv/multi_timer_table_core.sv
// timer slot table with serial period divider and slot walker
//
// channel | ports         | role
// req     | req_valid/stall | one command per transfer
// rsp     | rsp_valid/stall | one or more results per command
// csr     | apb-style       | four config registers, 4-byte spaced
//
// create and change_period run a 32-step restoring divide. tick walks the slots
// one per cycle, holding while an earlier expiry result still waits under rsp_stall.
// req_stall is high while a command is busy or an earlier result still waits.
// a result waits in the output register while rsp_stall is high.
// reset clears all slots at once (flip-flop table, no sweep).
`timescale 1ns / 1ps
module multi_timer_table_core #(
   parameter int N_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_handle,
   input  logic        req_mode_periodic,
   input  logic [31:0] req_period_ms,
   input  logic        req_cb_ok,
   input  logic [31:0] req_elapsed_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_handle_out,
   output logic        rsp_expired,
   output logic [1:0]  rsp_budget_event,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mtt_pkg::*;

   localparam int IW = (N_TIMERS > 1) ? $clog2(N_TIMERS) : 1;
   localparam int CW = $clog2(N_TIMERS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_DIV, S_APPLY, S_WALK, S_EMIT, S_DONE
   } state_type;

   state_type state_ff;
   logic [9:0]  tick_ms_ff;
   logic [31:0] soft_ff, hard_ff;
   logic [7:0]  strike_ff;

   logic [N_TIMERS-1:0] used_ff, armed_ff, per_ff;
   logic [31:0] reload_ff [N_TIMERS];
   logic [31:0] left_ff   [N_TIMERS];
   logic [7:0]  ovr_ff    [N_TIMERS];

   func_type    func_ff;
   logic [7:0]  h_ff;
   logic        mode_ff, ok_ff;
   logic [31:0] pms_ff, el_ff;

   // divider: quotient shifts into q_ff, remainder in r_ff
   logic [31:0] q_ff;
   logic [9:0]  r_ff;
   logic [5:0]  dcnt_ff;
   logic [IW-1:0] free_ff;
   logic        free_ok_ff;
   logic [CW-1:0] wcnt_ff;
   logic        any_ff;

   logic [1:0]  o_st_ff, o_be_ff;
   logic [7:0]  o_h_ff;
   logic        o_ex_ff, o_last_ff, o_v_ff;

   logic        wr;
   logic [IW-1:0] hi, wi;
   logic        inr, valid_h;
   logic [9:0]  dv;
   logic [10:0] rsh, rsub;
   logic [31:0] tks, dec;
   logic [7:0]  ovr_inc;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   assign req_stall = (state_ff != S_IDLE) || (o_v_ff && rsp_stall);
   assign rsp_valid = o_v_ff;
   assign rsp_status = o_st_ff;
   assign rsp_handle_out = o_h_ff;
   assign rsp_expired = o_ex_ff;
   assign rsp_budget_event = o_be_ff;
   assign rsp_last = o_last_ff;

   always_comb begin
      case (paddr[3:2])
         REG_TICK:   prdata = {22'd0, tick_ms_ff};
         REG_SOFT:   prdata = soft_ff;
         REG_HARD:   prdata = hard_ff;
         REG_STRIKE: prdata = {24'd0, strike_ff};
         default:    prdata = 32'd0;
      endcase
   end

   assign hi = h_ff[IW-1:0];
   assign wi = wcnt_ff[IW-1:0];
   assign inr = ({24'd0, h_ff} < 32'(N_TIMERS));
   assign valid_h = inr && used_ff[hi];
   assign dv = (tick_ms_ff == 10'd0) ? 10'd1 : tick_ms_ff;
   assign rsh = {r_ff, pms_ff[31]};
   assign rsub = rsh - {1'b0, dv};
   assign tks = (q_ff == 32'd0) ? 32'd1 : q_ff;
   assign dec = (left_ff[wi] != 32'd0) ? left_ff[wi] - 32'd1 : 32'd0;
   assign ovr_inc = ovr_ff[hi] + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tick_ms_ff <= 10'd1;
         soft_ff <= 32'd100;
         hard_ff <= 32'd500;
         strike_ff <= 8'd3;
         used_ff <= '0;
         armed_ff <= '0;
         per_ff <= '0;
         o_v_ff <= 1'b0;
         for (int i = 0; i < N_TIMERS; i++) begin
            reload_ff[i] <= 32'd0;
            left_ff[i] <= 32'd0;
            ovr_ff[i] <= 8'd0;
         end
      end else begin
         if (wr) begin
            case (paddr[3:2])
               REG_TICK:   tick_ms_ff <= pwdata[9:0];
               REG_SOFT:   soft_ff <= pwdata;
               REG_HARD:   hard_ff <= pwdata;
               REG_STRIKE: strike_ff <= pwdata[7:0];
               default: ;
            endcase
         end
         if (o_v_ff && !rsp_stall) o_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  func_ff <= func_type'(req_func);
                  h_ff <= req_handle;
                  mode_ff <= req_mode_periodic;
                  pms_ff <= req_period_ms;
                  ok_ff <= req_cb_ok;
                  el_ff <= req_elapsed_us;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               // result defaults
               o_st_ff <= ST_OK;
               o_h_ff <= 8'd0;
               o_ex_ff <= 1'b0;
               o_be_ff <= BE_NONE;
               o_last_ff <= 1'b1;
               q_ff <= 32'd0;
               r_ff <= 10'd0;
               dcnt_ff <= 6'd0;
               wcnt_ff <= '0;
               any_ff <= 1'b0;
               free_ok_ff <= 1'b0;
               free_ff <= '0;
               for (int i = N_TIMERS - 1; i >= 0; i--) begin
                  if (!used_ff[i]) begin
                     free_ok_ff <= 1'b1;
                     free_ff <= IW'(i);
                  end
               end
               state_ff <= S_DONE;
               case (func_ff)
                  FN_CREATE: begin
                     if (pms_ff == 32'd0) o_st_ff <= ST_INVAL;
                     else if (&used_ff) o_st_ff <= ST_FULL;
                     else state_ff <= S_DIV;
                  end
                  FN_CHPER: begin
                     if (!valid_h || pms_ff == 32'd0) o_st_ff <= ST_INVAL;
                     else state_ff <= S_DIV;
                  end
                  FN_START: begin
                     if (!valid_h) o_st_ff <= ST_INVAL;
                     else begin
                        left_ff[hi] <= reload_ff[hi];
                        armed_ff[hi] <= 1'b1;
                        ovr_ff[hi] <= 8'd0;
                     end
                  end
                  FN_STOP: begin
                     if (!inr) o_st_ff <= ST_INVAL;
                     else armed_ff[hi] <= 1'b0;
                  end
                  FN_DESTROY: begin
                     if (!inr) o_st_ff <= ST_INVAL;
                     else begin
                        used_ff[hi] <= 1'b0;
                        armed_ff[hi] <= 1'b0;
                        per_ff[hi] <= 1'b0;
                        reload_ff[hi] <= 32'd0;
                        left_ff[hi] <= 32'd0;
                        ovr_ff[hi] <= 8'd0;
                     end
                  end
                  FN_TICK: state_ff <= S_WALK;
                  FN_REPORT: begin
                     if (!valid_h) o_st_ff <= ST_INVAL;
                     else begin
                        if (el_ff > hard_ff) begin
                           if (ovr_inc >= strike_ff) begin
                              o_be_ff <= BE_FAULT;
                              ovr_ff[hi] <= 8'd0;
                           end else begin
                              o_be_ff <= BE_WARN;
                              ovr_ff[hi] <= ovr_inc;
                           end
                        end else begin
                           if (el_ff > soft_ff) o_be_ff <= BE_WARN;
                           ovr_ff[hi] <= 8'd0;
                        end
                        if (!ok_ff) armed_ff[hi] <= 1'b0;
                     end
                  end
                  default: o_st_ff <= ST_INVAL;
               endcase
            end
            S_DIV: begin
               // one quotient bit per cycle
               if (rsh >= {1'b0, dv}) begin
                  r_ff <= rsub[9:0];
                  q_ff <= {q_ff[30:0], 1'b1};
               end else begin
                  r_ff <= rsh[9:0];
                  q_ff <= {q_ff[30:0], 1'b0};
               end
               pms_ff <= {pms_ff[30:0], 1'b0};
               dcnt_ff <= dcnt_ff + 6'd1;
               if (dcnt_ff == 6'd31) state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (func_ff == FN_CREATE) begin
                  used_ff[free_ff] <= 1'b1;
                  armed_ff[free_ff] <= 1'b0;
                  per_ff[free_ff] <= mode_ff;
                  reload_ff[free_ff] <= tks;
                  left_ff[free_ff] <= tks;
                  ovr_ff[free_ff] <= 8'd0;
                  o_h_ff <= 8'(free_ff);
               end else begin
                  reload_ff[hi] <= tks;
                  if (armed_ff[hi] && left_ff[hi] > tks) left_ff[hi] <= tks;
                  ovr_ff[hi] <= 8'd0;
               end
               state_ff <= S_DONE;
            end
            S_WALK: begin
               if (wcnt_ff == CW'(N_TIMERS)) begin
                  if (!any_ff) state_ff <= S_DONE;
                  else state_ff <= S_IDLE;
               end else if (!o_v_ff || !rsp_stall) begin
                  wcnt_ff <= wcnt_ff + CW'(1);
                  if (used_ff[wi] && armed_ff[wi]) begin
                     if (dec == 32'd0) begin
                        if (per_ff[wi]) left_ff[wi] <= reload_ff[wi];
                        else begin
                           left_ff[wi] <= dec;
                           armed_ff[wi] <= 1'b0;
                        end
                        any_ff <= 1'b1;
                        o_h_ff <= 8'(wi);
                        o_ex_ff <= 1'b1;
                        o_last_ff <= 1'b1;
                        // last flag: no later slot expires this tick
                        for (int j = 0; j < N_TIMERS; j++) begin
                           if (j > int'(wi) && used_ff[j] && armed_ff[j]
                               && left_ff[j] <= 32'd1)
                              o_last_ff <= 1'b0;
                        end
                        o_v_ff <= 1'b1;
                     end else left_ff[wi] <= dec;
                  end
               end
            end
            S_DONE: begin
               if (!o_v_ff || !rsp_stall) begin
                  o_v_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // the output register is only loaded once the previous result left
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped under stall");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("command accepted while busy");
   a_expiry_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_expired) |-> ({24'd0, rsp_handle_out} < 32'(N_TIMERS)))
      else $error("expiry for slot out of range");
endmodule
